>>> src/oahi_pkg.sv
package oahi_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    localparam int KEY_W  = 31;
    localparam int SLOT_W = 7;
    localparam int SIZE_W = 8;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd127;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture request, start the home-slot remainder
        logic mod_step;  // one restoring-division step on the key
        logic probe;     // a probe read is in flight, examine it next cycle
        logic advance;   // step the probe index
        logic clr;       // clear valid bits and counters
        logic rd;        // read slot for a read request
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_done;
        logic lin_done;
        logic quad_done;
        logic probes_done;
    } t_sts;

endpackage

>>> src/oahi_ctrl.sv
module oahi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic [1:0]      i_req_type,
    input  oahi_pkg::t_sts  i_sts,
    input  logic            i_res_free,
    output logic            o_req_ready,
    output oahi_pkg::t_cmd  o_cmd,
    output logic            o_res_load
);

    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_ISSUE, S_CHECK, S_DONE, S_READ
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_res_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    case (oahi_pkg::t_req'(i_req_type))
                        oahi_pkg::REQ_INSERT: n_state = S_MOD;
                        oahi_pkg::REQ_CLEAR: begin
                            o_cmd.clr = 1'b1;
                            n_state   = S_DONE;
                        end
                        oahi_pkg::REQ_READ: begin
                            o_cmd.rd = 1'b1;
                            n_state  = S_READ;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) n_state = S_ISSUE;
            end
            S_ISSUE: begin
                o_cmd.probe = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if ((i_sts.lin_done && i_sts.quad_done) || i_sts.probes_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_ISSUE;
                end
            end
            S_READ: n_state = S_DONE;
            S_DONE: begin
                if (i_res_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

endmodule

>>> src/oahi_dp.sv
module oahi_dp #(
    parameter int TABLE_DEPTH = 128,
    parameter int COUNT_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  oahi_pkg::t_cmd              i_cmd,
    input  logic                        i_res_load,
    input  logic                        i_res_take,
    input  logic                        i_cfg_we,
    input  logic [oahi_pkg::SIZE_W-1:0] i_cfg_size,
    input  logic [oahi_pkg::KEY_W-1:0]  i_key,
    input  logic [oahi_pkg::SLOT_W-1:0] i_slot_index,
    output oahi_pkg::t_sts              o_sts,
    output logic                        o_res_valid,
    output logic [oahi_pkg::SLOT_W-1:0] o_linear_slot,
    output logic                        o_linear_placed,
    output logic [oahi_pkg::SLOT_W-1:0] o_quad_slot,
    output logic                        o_quad_placed,
    output logic [15:0]                 o_linear_collisions,
    output logic [15:0]                 o_quad_collisions,
    output logic [oahi_pkg::KEY_W-1:0]  o_read_linear_key,
    output logic                        o_read_linear_valid,
    output logic [oahi_pkg::KEY_W-1:0]  o_read_quad_key,
    output logic                        o_read_quad_valid
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = AW + 1;               // holds 0..TABLE_DEPTH
    localparam int KW = oahi_pkg::KEY_W;
    localparam int SW = oahi_pkg::SLOT_W;
    localparam int XW = (PW > oahi_pkg::SIZE_W) ? PW : oahi_pkg::SIZE_W;
    localparam int KSTEPS = KW;

    logic [KW-1:0] lin_mem [TABLE_DEPTH];
    logic [KW-1:0] quad_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_lin_occ, r_quad_occ;

    logic [oahi_pkg::SIZE_W-1:0] r_cfg;
    logic [PW-1:0] eff_size;
    logic [XW-1:0] cfg_x;

    assign cfg_x = XW'(r_cfg);
    always_comb begin
        if (r_cfg == '0) eff_size = PW'(1);
        else if (cfg_x > XW'(TABLE_DEPTH)) eff_size = PW'(TABLE_DEPTH);
        else eff_size = PW'(r_cfg);
    end

    // Request capture and restoring remainder, one key bit a cycle.
    logic [KW-1:0] r_key, r_shift;
    logic [PW:0]   r_rem;
    logic [5:0]    r_mcnt;
    logic [PW:0]   rem_sh;

    assign rem_sh = {r_rem[PW-1:0], r_shift[KW-1]};

    // Probe state.
    logic [PW-1:0] r_i;
    logic [PW-1:0] r_lpos, r_qpos, r_qinc;
    logic          r_ldone, r_qdone, r_lok, r_qok;
    logic [PW-1:0] r_lslot, r_qslot;
    logic          r_lchk, r_qchk;
    logic [COUNT_BITS-1:0] r_lcnt, r_qcnt;

    logic [AW-1:0] lidx, qidx;
    assign lidx = r_lpos[AW-1:0];
    assign qidx = r_qpos[AW-1:0];

    logic l_free, q_free;
    assign l_free = !r_lin_occ[lidx];
    assign q_free = !r_quad_occ[qidx];

    // Wrap helper: a + b where both below size, stays below twice size.
    function automatic logic [PW-1:0] wrap(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                           input logic [PW-1:0] m);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[PW-1:0];
    endfunction

    logic [PW-1:0] n_qinc;
    assign n_qinc = wrap(r_qinc, PW'(2), eff_size);

    assign o_sts.mod_done    = (r_mcnt == 6'(KSTEPS));
    assign o_sts.lin_done    = r_ldone;
    assign o_sts.quad_done   = r_qdone;
    assign o_sts.probes_done = (r_i == eff_size - PW'(1)) && r_lchk;

    logic [COUNT_BITS-1:0] cnt_max;
    assign cnt_max = '1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= oahi_pkg::SIZE_RESET;
            r_lin_occ  <= '0;
            r_quad_occ <= '0;
            r_lcnt     <= '0;
            r_qcnt     <= '0;
            r_lchk     <= 1'b0;
            r_qchk     <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_size;
            r_lchk <= i_cmd.probe;
            r_qchk <= i_cmd.probe;
            if (i_cmd.clr) begin
                r_lin_occ  <= '0;
                r_quad_occ <= '0;
                r_lcnt     <= '0;
                r_qcnt     <= '0;
            end
            // Evaluate the probe in the cycle after it was issued.
            if (r_lchk && !r_ldone && (eff_size > PW'(0)) && l_free
                    && (r_lpos < PW'(TABLE_DEPTH))) begin
                r_lin_occ[lidx] <= 1'b1;
                if (r_i != '0 && r_lcnt != cnt_max) r_lcnt <= r_lcnt + 1'b1;
            end
            if (r_qchk && !r_qdone && q_free && (r_qpos < PW'(TABLE_DEPTH))) begin
                r_quad_occ[qidx] <= 1'b1;
                if (r_i != '0 && r_qcnt != cnt_max) r_qcnt <= r_qcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_key;
            r_shift <= i_key;
            r_rem   <= '0;
            r_mcnt  <= '0;
        end
        if (i_cmd.mod_step && r_mcnt != 6'(KSTEPS)) begin
            r_shift <= {r_shift[KW-2:0], 1'b0};
            r_mcnt  <= r_mcnt + 6'd1;
            if (rem_sh >= {1'b0, eff_size}) r_rem <= rem_sh - {1'b0, eff_size};
            else r_rem <= rem_sh;
            if (r_mcnt == 6'(KSTEPS - 1)) begin
                r_i     <= '0;
                r_qinc  <= wrap('0, PW'(1), eff_size);
                r_ldone <= 1'b0;
                r_qdone <= 1'b0;
                r_lok   <= 1'b0;
                r_qok   <= 1'b0;
                r_lslot <= '0;
                r_qslot <= '0;
                if (rem_sh >= {1'b0, eff_size}) begin
                    r_lpos <= PW'(rem_sh - {1'b0, eff_size});
                    r_qpos <= PW'(rem_sh - {1'b0, eff_size});
                end else begin
                    r_lpos <= PW'(rem_sh);
                    r_qpos <= PW'(rem_sh);
                end
            end
        end
        if (r_lchk && !r_ldone && l_free && (r_lpos < PW'(TABLE_DEPTH))) begin
            lin_mem[lidx] <= r_key;
            r_ldone <= 1'b1;
            r_lok   <= 1'b1;
            r_lslot <= r_lpos;
        end
        if (r_qchk && !r_qdone && q_free && (r_qpos < PW'(TABLE_DEPTH))) begin
            quad_mem[qidx] <= r_key;
            r_qdone <= 1'b1;
            r_qok   <= 1'b1;
            r_qslot <= r_qpos;
        end
        if (i_cmd.advance) begin
            // (h + (i+1)^2) = (h + i^2) + (2i+1); increment kept modulo size.
            r_i    <= r_i + PW'(1);
            r_lpos <= wrap(r_lpos, PW'(1), eff_size);
            r_qpos <= wrap(r_qpos, r_qinc, eff_size);
            r_qinc <= n_qinc;
        end
    end

    // Read port for read requests, registered.
    logic [KW-1:0] r_rlk, r_rqk;
    logic          r_rlv, r_rqv, r_isread, r_isins;
    logic [AW-1:0] ridx;
    logic          rin;
    assign rin  = (32'(i_slot_index) < 32'(TABLE_DEPTH));
    assign ridx = AW'(i_slot_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_isread <= i_cmd.rd;
        if (i_cmd.load) r_isins <= 1'b0;
        else if (i_cmd.mod_step) r_isins <= 1'b1;
        if (i_cmd.rd) begin
            r_rlk <= lin_mem[ridx];
            r_rqk <= quad_mem[ridx];
            r_rlv <= rin && r_lin_occ[ridx];
            r_rqv <= rin && r_quad_occ[ridx];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else begin
            if (i_res_load) o_res_valid <= 1'b1;
            else if (i_res_take) o_res_valid <= 1'b0;
        end
        if (i_res_load) begin
            o_linear_placed     <= r_isins && r_lok;
            o_quad_placed       <= r_isins && r_qok;
            o_linear_slot       <= (r_isins && r_lok) ? SW'(r_lslot) : '0;
            o_quad_slot         <= (r_isins && r_qok) ? SW'(r_qslot) : '0;
            o_linear_collisions <= 16'(r_lcnt);
            o_quad_collisions   <= 16'(r_qcnt);
            o_read_linear_valid <= r_isread && r_rlv;
            o_read_quad_valid   <= r_isread && r_rqv;
            o_read_linear_key   <= (r_isread && r_rlv) ? r_rlk : '0;
            o_read_quad_key     <= (r_isread && r_rqv) ? r_rqk : '0;
        end
    end

endmodule

>>> src/open_addressing_hash_insert.sv
// Inserts each key into a linear-probing and a quadratic-probing table at once,
// both probed in lockstep. An insert first forms key mod size (one key bit a
// cycle), then issues and checks each probe in turn, and then hands the result
// to the output register once it is free. Probing goes on one probe past the
// last placement and never beyond as many probes as the effective size
// (table_size clamped to 1..TABLE_DEPTH). A clear needs no probing and a read
// only a registered slot read. One request is handled at a time; a finished
// result sits in the output register until taken.
module open_addressing_hash_insert #(
    parameter int TABLE_DEPTH = 128,
    parameter int COUNT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_table_size,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [30:0] i_key,
    input  logic [6:0]  i_slot_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_linear_slot,
    output logic        o_linear_placed,
    output logic [6:0]  o_quad_slot,
    output logic        o_quad_placed,
    output logic [15:0] o_linear_collisions,
    output logic [15:0] o_quad_collisions,
    output logic [30:0] o_read_linear_key,
    output logic        o_read_linear_valid,
    output logic [30:0] o_read_quad_key,
    output logic        o_read_quad_valid
);

    oahi_pkg::t_cmd cmd;
    oahi_pkg::t_sts sts;
    logic           res_load, res_free;

    assign o_cfg_ready = 1'b1;
    assign res_free    = !o_valid || i_ready;

    oahi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req_type  (i_req_type),
        .i_sts       (sts),
        .i_res_free  (res_free),
        .o_req_ready (o_ready),
        .o_cmd       (cmd),
        .o_res_load  (res_load)
    );

    oahi_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_res_load          (res_load),
        .i_res_take          (o_valid && i_ready),
        .i_cfg_we            (i_cfg_valid),
        .i_cfg_size          (i_table_size),
        .i_key               (i_key),
        .i_slot_index        (i_slot_index),
        .o_sts               (sts),
        .o_res_valid         (o_valid),
        .o_linear_slot       (o_linear_slot),
        .o_linear_placed     (o_linear_placed),
        .o_quad_slot         (o_quad_slot),
        .o_quad_placed       (o_quad_placed),
        .o_linear_collisions (o_linear_collisions),
        .o_quad_collisions   (o_quad_collisions),
        .o_read_linear_key   (o_read_linear_key),
        .o_read_linear_valid (o_read_linear_valid),
        .o_read_quad_key     (o_read_quad_key),
        .o_read_quad_valid   (o_read_quad_valid)
    );

`ifndef SYNTH
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> (!o_valid || i_ready)) else $error("result overwritten");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("second request taken");
    a_placed_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_linear_placed) |-> (o_linear_slot == 7'd0))
        else $error("slot without placement");
`endif

endmodule
